### hw/rtl/line_from_two_points_defines.svh
// Assertion macros used by the checker file of the line block.
// Depends on nothing; included by the checker module.
`ifndef LINE_FROM_TWO_POINTS_DEFINES_SVH
`define LINE_FROM_TWO_POINTS_DEFINES_SVH
// Asserts that an implication holds at every clock edge outside reset.
`define LFTP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Asserts that an implication holds, also during reset.
`define LFTP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### hw/rtl/lftp_pkg.sv
// Package of the line block: widths, CORDIC arctangent table and helpers.
// Depends on nothing; used by line_from_two_points and lftp_cordic.
package lftp_pkg;
   localparam int CoordWidth = 16;
   localparam int AtanSteps = 24;
   localparam int DefaultIterations = 16;
   localparam int WorkWidth = 36;
   localparam int AccWidth = 32;
   localparam logic [16:0] InvGain = 17'd39797;

   localparam logic [1:0] KIND_GENERAL = 2'd0;
   localparam logic [1:0] KIND_SAME = 2'd1;
   localparam logic [1:0] KIND_VERT = 2'd2;
   localparam logic [1:0] KIND_HORZ = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [15:0] fixed_angle;
      logic [15:0] fixed_dist;
   } side_type;

   function automatic logic [AccWidth-1:0] atan_turn(input int idx);
      logic [AccWidth-1:0] r;
      begin
         case (idx)
            0: r = 32'd536870912;
            1: r = 32'd316933406;
            2: r = 32'd167458907;
            3: r = 32'd85004756;
            4: r = 32'd42667331;
            5: r = 32'd21354465;
            6: r = 32'd10679838;
            7: r = 32'd5340245;
            8: r = 32'd2670163;
            9: r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = '0;
         endcase
         return r;
      end
   endfunction
endpackage

### hw/rtl/lftp_cordic.sv
// Pipelined vectoring CORDIC of the line block: one micro-rotation per stage.
// Depends on lftp_pkg; instantiated by line_from_two_points.
module lftp_cordic
   import lftp_pkg::*;
#(
   parameter int ITERATIONS = DefaultIterations
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic signed [WorkWidth-1:0] in_vx,
   input  logic signed [WorkWidth-1:0] in_vy,
   input  logic signed [WorkWidth-1:0] in_py,
   input  logic signed [WorkWidth-1:0] in_px,
   input  logic [AccWidth-1:0] in_acc,
   input  side_type in_side,
   output logic out_valid,
   output logic signed [WorkWidth-1:0] out_py,
   output logic [AccWidth-1:0] out_acc,
   output side_type out_side
);
   localparam int Stages = (ITERATIONS > AtanSteps) ? AtanSteps : ITERATIONS;

   logic valid_ff [Stages];
   logic signed [WorkWidth-1:0] vx_ff [Stages];
   logic signed [WorkWidth-1:0] vy_ff [Stages];
   logic signed [WorkWidth-1:0] px_ff [Stages];
   logic signed [WorkWidth-1:0] py_ff [Stages];
   logic [AccWidth-1:0] acc_ff [Stages];
   side_type side_ff [Stages];

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic valid_cur;
      logic signed [WorkWidth-1:0] vx_cur, vy_cur, px_cur, py_cur;
      logic [AccWidth-1:0] acc_cur;
      side_type side_cur;
      logic signed [WorkWidth-1:0] vx_in, vy_in, px_in, py_in;
      logic [AccWidth-1:0] acc_in;
      if (s == 0) begin : g_head
         assign valid_cur = in_valid;
         assign vx_cur = in_vx;
         assign vy_cur = in_vy;
         assign px_cur = in_px;
         assign py_cur = in_py;
         assign acc_cur = in_acc;
         assign side_cur = in_side;
      end else begin : g_link
         assign valid_cur = valid_ff[s-1];
         assign vx_cur = vx_ff[s-1];
         assign vy_cur = vy_ff[s-1];
         assign px_cur = px_ff[s-1];
         assign py_cur = py_ff[s-1];
         assign acc_cur = acc_ff[s-1];
         assign side_cur = side_ff[s-1];
      end
      always_comb begin
         if (!vy_cur[WorkWidth-1]) begin
            vx_in = vx_cur + (vy_cur >>> s);
            vy_in = vy_cur - (vx_cur >>> s);
            px_in = px_cur + (py_cur >>> s);
            py_in = py_cur - (px_cur >>> s);
            acc_in = acc_cur + atan_turn(s);
         end else begin
            vx_in = vx_cur - (vy_cur >>> s);
            vy_in = vy_cur + (vx_cur >>> s);
            px_in = px_cur - (py_cur >>> s);
            py_in = py_cur + (px_cur >>> s);
            acc_in = acc_cur - atan_turn(s);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_cur;
         end
         if (advance) begin
            vx_ff[s] <= vx_in;
            vy_ff[s] <= vy_in;
            px_ff[s] <= px_in;
            py_ff[s] <= py_in;
            acc_ff[s] <= acc_in;
            side_ff[s] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[Stages-1];
   assign out_py = py_ff[Stages-1];
   assign out_acc = acc_ff[Stages-1];
   assign out_side = side_ff[Stages-1];
endmodule

### hw/rtl/line_from_two_points.sv
// Line through two points in Hesse normal form; top level of the block.
// Throughput: one item per cycle; each CORDIC step is one pipeline stage.
// The whole pipeline stalls together when the output is held back.
// Synchronous active-high reset clears all valid bits; payload is not reset.
// Depends on lftp_pkg and lftp_cordic.
module line_from_two_points
   import lftp_pkg::*;
#(
   parameter int ANGLE_ITERATIONS = DefaultIterations
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // first_x [15:0], first_y [31:16], second_x [47:32], second_y [63:48]
   input  logic [63:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // normal_angle [15:0], origin_distance [31:16], status [32], zero [39:33]
   output logic [39:0] rsp_tdata
);
   logic advance;
   logic signed [15:0] x1, y1, x2, y2;

   logic a_valid_ff;
   logic signed [16:0] a_dx_ff, a_dy_ff;
   logic signed [15:0] a_x1_ff, a_y1_ff;
   side_type a_side_ff;

   logic b_valid_ff;
   logic signed [WorkWidth-1:0] b_vx_ff, b_vy_ff, b_px_ff, b_py_ff;
   logic [AccWidth-1:0] b_acc_ff;
   side_type b_side_ff;

   logic c_valid;
   logic signed [WorkWidth-1:0] c_py;
   logic [AccWidth-1:0] c_acc;
   side_type c_side;

   logic d_valid_ff;
   logic signed [WorkWidth+17:0] d_prod_ff;
   logic [15:0] d_angle_ff;
   side_type d_side_ff;

   logic o_valid_ff;
   logic [15:0] o_angle_ff, o_dist_ff;
   logic o_status_ff;

   assign advance = !o_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign x1 = req_tdata[15:0];
   assign y1 = req_tdata[31:16];
   assign x2 = req_tdata[47:32];
   assign y2 = req_tdata[63:48];

   side_type a_side_in;
   always_comb begin
      a_side_in.kind = KIND_GENERAL;
      a_side_in.fixed_angle = '0;
      a_side_in.fixed_dist = '0;
      if (x1 == x2 && y1 == y2) begin
         a_side_in.kind = KIND_SAME;
      end else if (x1 == x2) begin
         a_side_in.kind = KIND_VERT;
         a_side_in.fixed_angle = (x1 > 0) ? 16'd0 : 16'd32768;
         a_side_in.fixed_dist = x1[15] ? 16'(-x1) : x1;
      end else if (y1 == y2) begin
         a_side_in.kind = KIND_HORZ;
         a_side_in.fixed_angle = (y1 > 0) ? 16'd16384 : 16'd49152;
         a_side_in.fixed_dist = y1[15] ? 16'(-y1) : y1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
         d_valid_ff <= c_valid;
         o_valid_ff <= d_valid_ff;
      end
   end

   // Stage A: differences and case split.
   always_ff @(posedge clock) begin
      if (advance) begin
         a_dx_ff <= 17'(x2) - 17'(x1);
         a_dy_ff <= 17'(y2) - 17'(y1);
         a_x1_ff <= x1;
         a_y1_ff <= y1;
         a_side_ff <= a_side_in;
      end
   end

   // Stage B: fold the direction into the upper half plane and the right quadrant.
   logic signed [17:0] fx, fy, b_vx_in, b_vy_in, b_px_in, b_py_in;
   logic [AccWidth-1:0] b_acc_in;
   always_comb begin
      fx = a_dy_ff[16] ? -18'(a_dx_ff) : 18'(a_dx_ff);
      fy = a_dy_ff[16] ? -18'(a_dy_ff) : 18'(a_dy_ff);
      if (fx[17]) begin
         b_vx_in = fy;
         b_vy_in = -fx;
         b_px_in = 18'(a_y1_ff);
         b_py_in = -18'(a_x1_ff);
         b_acc_in = 32'h4000_0000;
      end else begin
         b_vx_in = fx;
         b_vy_in = fy;
         b_px_in = 18'(a_x1_ff);
         b_py_in = 18'(a_y1_ff);
         b_acc_in = '0;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         b_vx_ff <= {(WorkWidth-8)'(b_vx_in), 8'd0};
         b_vy_ff <= {(WorkWidth-8)'(b_vy_in), 8'd0};
         b_px_ff <= {(WorkWidth-8)'(b_px_in), 8'd0};
         b_py_ff <= {(WorkWidth-8)'(b_py_in), 8'd0};
         b_acc_ff <= b_acc_in;
         b_side_ff <= a_side_ff;
      end
   end

   lftp_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_cordic (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(b_valid_ff), .in_vx(b_vx_ff), .in_vy(b_vy_ff),
      .in_py(b_py_ff), .in_px(b_px_ff), .in_acc(b_acc_ff), .in_side(b_side_ff),
      .out_valid(c_valid), .out_py(c_py), .out_acc(c_acc), .out_side(c_side)
   );

   // Stage D: gain correction and angle rounding.
   logic [AccWidth-1:0] acc_rnd;
   assign acc_rnd = c_acc + 32'h0000_8000;
   always_ff @(posedge clock) begin
      if (advance) begin
         d_prod_ff <= (WorkWidth+18)'(c_py) * $signed({1'b0, InvGain});
         d_angle_ff <= acc_rnd[31:16] + 16'd16384;
         d_side_ff <= c_side;
      end
   end

   // Stage E: magnitude, rounding, saturation and selection.
   logic [WorkWidth+17:0] mag_abs, mag_rnd;
   logic [WorkWidth-7:0] mag;
   logic [15:0] gen_angle, gen_dist;
   always_comb begin
      mag_abs = d_prod_ff[WorkWidth+17] ? (WorkWidth+18)'(-d_prod_ff) : d_prod_ff;
      mag_rnd = mag_abs + (WorkWidth+18)'(24'h80_0000);
      mag = mag_rnd[WorkWidth+17:24];
      gen_angle = (mag != '0 && d_prod_ff[WorkWidth+17]) ? d_angle_ff + 16'd32768
                                                          : d_angle_ff;
      gen_dist = (mag > (WorkWidth-6)'(16'hFFFF)) ? 16'hFFFF : mag[15:0];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         case (d_side_ff.kind)
            KIND_GENERAL: begin
               o_angle_ff <= gen_angle;
               o_dist_ff <= gen_dist;
               o_status_ff <= 1'b0;
            end
            KIND_SAME: begin
               o_angle_ff <= '0;
               o_dist_ff <= '0;
               o_status_ff <= 1'b1;
            end
            default: begin
               o_angle_ff <= d_side_ff.fixed_angle;
               o_dist_ff <= d_side_ff.fixed_dist;
               o_status_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata = {7'd0, o_status_ff, o_dist_ff, o_angle_ff};
endmodule

### hw/rtl/lftp_checker.sv
// Port-level checker of the line block, bound to line_from_two_points.
// Depends on line_from_two_points_defines.svh.
`include "line_from_two_points_defines.svh"
module lftp_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [39:0] rsp_tdata
);
   `LFTP_ASSERT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled item changed")
   `LFTP_ASSERT(a_ready_free, clock, reset, !rsp_tvalid |-> req_tready, "input blocked while output empty")
   `LFTP_ASSERT(a_pad_zero, clock, reset, rsp_tvalid |-> rsp_tdata[39:33] == 7'd0, "padding not zero")
   `LFTP_ASSERT(a_same_zero, clock, reset, rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[31:0] == 32'd0, "coincident item not zero")
   `LFTP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "output valid after reset")
endmodule

bind line_from_two_points lftp_checker u_lftp_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
